// ----- rtl/som_pkg.sv -----
// Shared types and fixed field widths for the segmentation overlap metrics unit.
// No dependencies; imported by every module of the block.
package som_pkg;

  // Fixed widths of the result fields
  localparam int CNT_OUT_W = 25;
  localparam int RATIO_W   = 17;
  localparam int MASK_W    = 4;

  // Result packing: six counts, four ratios, the undefined mask, padded to bytes
  localparam int OUT_USED = 6 * CNT_OUT_W + 4 * RATIO_W + MASK_W;
  localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;
  localparam int OUT_PAD  = OUT_W - OUT_USED;

  // Snapshot queue between front and back
  localparam int FIFO_DEPTH = 2;

  // Ratio order, also the bit order of the undefined mask
  typedef enum logic [1:0] {
    R_JAC  = 2'd0,
    R_DICE = 2'd1,
    R_SENS = 2'd2,
    R_SPEC = 2'd3
  } ratio_sel_t;

  typedef struct packed {
    logic full;
    logic empty;
  } som_fifo_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } som_div_stat_t;

endpackage

// ----- rtl/segmentation_overlap_metrics_unit.sv -----
// Top level of the segmentation overlap metrics unit: voxel stream in, one metrics
// record per volume out. Depends on som_pkg, som_front, som_fifo and som_back.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+--------------------------------------------
//  s_*     | in  | s_tvalid / s_tready  | s_tdata: seg_voxel, ref_voxel; s_tlast: last
//  m_*     | out | m_tvalid / m_tready  | m_tdata: 6 counts, 4 ratios, undefined_mask
//
// Cycles: the front takes one voxel pair a request, every cycle, counting with saturation.
// The last pair of a volume drops a count snapshot into a two-entry queue and clears
// the counts; the front only stalls while that queue is full.
// The four ratios of a volume pass in turn through the single shared divider of the
// back, which produces one quotient bit per cycle.
// Reset (rst, synchronous) clears counts, queue and controllers; a result record holds
// on m_tdata until m_tready takes it, while the front keeps counting the next volume.
module segmentation_overlap_metrics_unit #(
  parameter longint unsigned MAX_VOXELS = 64'd16777216,
  parameter int FRAC_BITS = 16,
  parameter int VOXEL_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  // request in
  input  logic s_tvalid,
  output logic s_tready,
  // [VOXEL_BITS-1:0] seg_voxel, [2*VOXEL_BITS-1:VOXEL_BITS] ref_voxel, zero pad
  input  logic [((2*VOXEL_BITS+7)/8)*8-1:0] s_tdata,
  input  logic s_tlast,
  // result out
  output logic m_tvalid,
  input  logic m_tready,
  // size_seg, size_ref, true_pos, false_pos, false_neg, true_neg (25 each),
  // jaccard, dice, sensitivity, specificity (17 each), undefined_mask (4), zero pad
  output logic [som_pkg::OUT_W-1:0] m_tdata
);
  import som_pkg::*;

  // count width that can hold the saturation bound itself
  localparam int CNT_W  = $clog2(MAX_VOXELS + 1);
  localparam int SNAP_W = 4 * CNT_W;

  logic [VOXEL_BITS-1:0] seg_voxel, ref_voxel;
  logic                  push, pop;
  logic [SNAP_W-1:0]     push_data, snap_data;
  som_fifo_stat_t        fstat;

  // unpack the request payload
  assign seg_voxel = s_tdata[VOXEL_BITS-1:0];
  assign ref_voxel = s_tdata[2*VOXEL_BITS-1:VOXEL_BITS];

  som_front #(
    .MAX_VOXELS (MAX_VOXELS),
    .CNT_W      (CNT_W),
    .VOXEL_BITS (VOXEL_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .seg_voxel  (seg_voxel),
    .ref_voxel  (ref_voxel),
    .last_voxel (s_tlast),
    .fstat      (fstat),
    .push       (push),
    .push_data  (push_data)
  );

  som_fifo #(
    .WIDTH (SNAP_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (snap_data),
    .stat      (fstat)
  );

  som_back #(
    .CNT_W     (CNT_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .fstat     (fstat),
    .snap_data (snap_data),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ----- rtl/som_front.sv -----
// Front end: classifies voxel pairs and keeps the saturating volume counts.
// Depends on som_pkg; pushes one count snapshot per volume into som_fifo.
module som_front #(
  parameter longint unsigned MAX_VOXELS = 64'd16777216,
  parameter int CNT_W = 25,
  parameter int VOXEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [VOXEL_BITS-1:0] seg_voxel,
  input  logic [VOXEL_BITS-1:0] ref_voxel,
  input  logic                  last_voxel,
  input  som_pkg::som_fifo_stat_t fstat,
  output logic                  push,
  output logic [4*CNT_W-1:0]    push_data
);
  import som_pkg::*;

  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_VOXELS);

  logic [CNT_W-1:0] total_cnt, seg_cnt, ref_cnt, both_cnt;
  logic [CNT_W-1:0] total_next, seg_next, ref_next, both_next;
  logic             seg_fg, ref_fg, accept;

  // Foreground: nonzero with the sign bit clear
  assign seg_fg = (seg_voxel != '0) && !seg_voxel[VOXEL_BITS-1];
  assign ref_fg = (ref_voxel != '0) && !ref_voxel[VOXEL_BITS-1];

  assign s_tready = !fstat.full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    total_next = (total_cnt >= MAX_C) ? MAX_C : total_cnt + 1'b1;
    seg_next   = seg_cnt;
    ref_next   = ref_cnt;
    both_next  = both_cnt;
    if (seg_fg) begin
      seg_next = (seg_cnt >= MAX_C) ? MAX_C : seg_cnt + 1'b1;
    end
    if (ref_fg) begin
      ref_next = (ref_cnt >= MAX_C) ? MAX_C : ref_cnt + 1'b1;
    end
    if (seg_fg && ref_fg) begin
      both_next = (both_cnt >= MAX_C) ? MAX_C : both_cnt + 1'b1;
    end
  end

  assign push      = accept && last_voxel;
  assign push_data = {both_next, ref_next, seg_next, total_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      total_cnt <= '0;
      seg_cnt   <= '0;
      ref_cnt   <= '0;
      both_cnt  <= '0;
    end else if (accept) begin
      if (last_voxel) begin
        total_cnt <= '0;
        seg_cnt   <= '0;
        ref_cnt   <= '0;
        both_cnt  <= '0;
      end else begin
        total_cnt <= total_next;
        seg_cnt   <= seg_next;
        ref_cnt   <= ref_next;
        both_cnt  <= both_next;
      end
    end
  end

endmodule

// ----- rtl/som_fifo.sv -----
// Short snapshot queue between the counting front end and the ratio back end.
// Depends on som_pkg for the depth and the status struct.
module som_fifo #(
  parameter int WIDTH = 100
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic [WIDTH-1:0]        push_data,
  input  logic                    pop,
  output logic [WIDTH-1:0]        pop_data,
  output som_pkg::som_fifo_stat_t stat
);
  import som_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [WIDTH-1:0] entry [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign stat.full  = (count == CNT_W'(FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign pop_data   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!stat.full || pop))
    else $error("snapshot queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("snapshot queue read while empty");
`endif

endmodule

// ----- rtl/som_div.sv -----
// Restoring fixed-point divider, one quotient bit per cycle.
// Depends on som_pkg for the status struct; used by som_back.
module som_div #(
  parameter int W = 27,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [W-1:0]          num,
  input  logic [W-1:0]          den,
  output logic [FRAC_BITS:0]    quot,
  output som_pkg::som_div_stat_t stat
);
  import som_pkg::*;

  localparam int QW    = FRAC_BITS + 1;
  localparam int STEPW = $clog2(FRAC_BITS + 1);

  logic [W-1:0]     rem, dvs, rem_sh;
  logic [QW-1:0]    q;
  logic [STEPW-1:0] steps;
  logic             busy, done;

  assign rem_sh    = {rem[W-2:0], 1'b0};
  assign quot      = q;
  assign stat.busy = busy;
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= den;
      // integer bit: numerator never exceeds the denominator
      if (num >= den) begin
        rem <= num - den;
        q   <= QW'(1);
      end else begin
        rem <= num;
        q   <= '0;
      end
    end else if (busy) begin
      if (rem_sh >= dvs) begin
        rem <= rem_sh - dvs;
        q   <= {q[QW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q   <= {q[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEPW'(FRAC_BITS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEPW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTH
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider finished without running");
`endif

endmodule

// ----- rtl/som_back.sv -----
// Back end: turns a count snapshot into TP/FP/FN/TN and four fixed-point ratios.
// Depends on som_pkg and som_div; reads snapshots from som_fifo.
module som_back #(
  parameter int CNT_W = 25,
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  som_pkg::som_fifo_stat_t fstat,
  input  logic [4*CNT_W-1:0]      snap_data,
  output logic                    pop,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [som_pkg::OUT_W-1:0] m_tdata
);
  import som_pkg::*;

  localparam int W = CNT_W + 2;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PREP  = 6'b000010,
    S_TN    = 6'b000100,
    S_ISSUE = 6'b001000,
    S_WAIT  = 6'b010000,
    S_HOLD  = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]   total_s, seg_s, ref_s, both_s;
  logic [CNT_W-1:0]   fp_r, fn_r, tn_r;
  logic [W-1:0]       jac_den, dice_num, dice_den;
  logic [W-1:0]       sel_num, sel_den;
  ratio_sel_t         idx;
  logic               den_zero;
  logic [RATIO_W-1:0] ratio [4];
  logic [MASK_W-1:0]  undef_mask;
  logic               div_start;
  logic [FRAC_BITS:0] div_q;
  som_div_stat_t      div_stat;

  assign pop       = (state == S_IDLE) && !fstat.empty;
  assign div_start = (state == S_ISSUE);
  assign m_tvalid  = (state == S_HOLD);

  // Operand select for the shared divider
  always_comb begin
    case (idx)
      R_JAC: begin
        sel_num = W'(both_s);
        sel_den = jac_den;
      end
      R_DICE: begin
        sel_num = dice_num;
        sel_den = dice_den;
      end
      R_SENS: begin
        sel_num = W'(both_s);
        sel_den = W'(ref_s);
      end
      R_SPEC: begin
        sel_num = W'(tn_r);
        sel_den = W'(tn_r) + W'(fp_r);
      end
      default: begin
        sel_num = '0;
        sel_den = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (!fstat.empty) state_next = S_PREP;
      S_PREP:  state_next = S_TN;
      S_TN:    state_next = S_ISSUE;
      S_ISSUE: state_next = S_WAIT;
      S_WAIT: begin
        if (div_stat.done) begin
          state_next = (idx == R_SPEC) ? S_HOLD : S_ISSUE;
        end
      end
      S_HOLD:  if (m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (!fstat.empty) begin
          {both_s, ref_s, seg_s, total_s} <= snap_data;
        end
      end
      S_PREP: begin
        fp_r       <= seg_s - both_s;
        fn_r       <= ref_s - both_s;
        jac_den    <= W'(seg_s) + W'(ref_s) - W'(both_s);
        dice_num   <= W'(both_s) << 1;
        dice_den   <= W'(seg_s) + W'(ref_s);
        undef_mask <= '0;
      end
      S_TN: begin
        // clamp at zero when saturation pushes the foreground union past the total
        tn_r <= (W'(total_s) > jac_den) ? CNT_W'(W'(total_s) - jac_den) : '0;
        idx  <= R_JAC;
      end
      S_ISSUE: begin
        den_zero <= (sel_den == '0);
      end
      S_WAIT: begin
        if (div_stat.done) begin
          ratio[idx]      <= den_zero ? '0 : RATIO_W'(div_q);
          undef_mask[idx] <= den_zero;
          if (idx != R_SPEC) begin
            idx <= ratio_sel_t'(idx + 2'd1);
          end
        end
      end
      default: ;
    endcase
  end

  som_div #(
    .W         (W),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (sel_num),
    .den   (sel_den),
    .quot  (div_q),
    .stat  (div_stat)
  );

  assign m_tdata = {{OUT_PAD{1'b0}}, undef_mask,
                    ratio[R_SPEC], ratio[R_SENS], ratio[R_DICE], ratio[R_JAC],
                    CNT_OUT_W'(tn_r), CNT_OUT_W'(fn_r), CNT_OUT_W'(fp_r),
                    CNT_OUT_W'(both_s), CNT_OUT_W'(ref_s), CNT_OUT_W'(seg_s)};

`ifndef SYNTH
  a_start_idle_div: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");
  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && undef_mask[R_JAC]) |-> (ratio[R_JAC] == '0))
    else $error("undefined ratio reported as nonzero");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result dropped before it was taken");
`endif

endmodule

// ----- tb/sv/som_checker.sv -----
// Checker for the segmentation overlap metrics unit: watches both streams, predicts
// one metrics record per closed volume and compares each record field by field.
// Depends on som_pkg for the result field widths and the ratio order.
module som_checker #(
  parameter longint unsigned MAX_VOXELS = 64'd16777216,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_tready,
  input  logic [31:0] s_tdata,
  input  logic s_tlast,
  input  logic m_tvalid,
  input  logic m_tready,
  input  logic [som_pkg::OUT_W-1:0] m_tdata,
  output int errors,
  output int pending
);
  import som_pkg::*;

  // Same layout as m_tdata: first member is the most significant
  typedef struct packed {
    logic [OUT_PAD-1:0]   pad;
    logic [MASK_W-1:0]    undef_mask;
    logic [RATIO_W-1:0]   spec, sens, dice, jac;
    logic [CNT_OUT_W-1:0] tn, fn, fp, tp, ref_size, seg_size;
  } volume_metrics_t;

  longint unsigned vox_total, fg_seg, fg_ref, fg_both;
  volume_metrics_t metrics_due[$];

  function automatic longint unsigned bump(longint unsigned c);
    return (c >= MAX_VOXELS) ? MAX_VOXELS : c + 1;
  endfunction

  // Truncated num * 2^FRAC_BITS / den; flag the ratio when den is zero
  function automatic logic [RATIO_W-1:0] ratio_of(input longint unsigned num,
                                                  input longint unsigned den,
                                                  input ratio_sel_t sel,
                                                  inout logic [MASK_W-1:0] undef);
    if (den == 0) begin
      undef[sel] = 1'b1;
      return '0;
    end
    return RATIO_W'((num << FRAC_BITS) / den);
  endfunction

  function automatic volume_metrics_t close_volume();
    volume_metrics_t m;
    longint unsigned tp, fp, fn, tn, overlap;
    logic [MASK_W-1:0] undef;
    tp = fg_both;
    fp = fg_seg - tp;
    fn = fg_ref - tp;
    overlap = tp + fp + fn;
    // clamp when saturated counts leave nothing for the background
    tn = (vox_total > overlap) ? vox_total - overlap : 0;
    undef = '0;
    m = '0;
    m.seg_size = CNT_OUT_W'(fg_seg);
    m.ref_size = CNT_OUT_W'(fg_ref);
    m.tp = CNT_OUT_W'(tp);
    m.fp = CNT_OUT_W'(fp);
    m.fn = CNT_OUT_W'(fn);
    m.tn = CNT_OUT_W'(tn);
    m.jac = ratio_of(tp, overlap, R_JAC, undef);
    m.dice = ratio_of(2 * tp, fg_seg + fg_ref, R_DICE, undef);
    m.sens = ratio_of(tp, tp + fn, R_SENS, undef);
    m.spec = ratio_of(tn, tn + fp, R_SPEC, undef);
    m.undef_mask = undef;
    return m;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    volume_metrics_t got, want;
    logic seg_fg, ref_fg;
    if (rst) begin
      vox_total = 0;
      fg_seg = 0;
      fg_ref = 0;
      fg_both = 0;
      metrics_due.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (metrics_due.size() == 0) begin
          $error("metrics record with no closed volume waiting");
          errors++;
        end else begin
          want = metrics_due.pop_front();
          check_field("size_seg", want.seg_size, got.seg_size);
          check_field("size_ref", want.ref_size, got.ref_size);
          check_field("true_pos", want.tp, got.tp);
          check_field("false_pos", want.fp, got.fp);
          check_field("false_neg", want.fn, got.fn);
          check_field("true_neg", want.tn, got.tn);
          check_field("jaccard_ratio", want.jac, got.jac);
          check_field("dice_ratio", want.dice, got.dice);
          check_field("sensitivity_ratio", want.sens, got.sens);
          check_field("specificity_ratio", want.spec, got.spec);
          check_field("undefined_mask", want.undef_mask, got.undef_mask);
        end
      end
      if (s_tvalid && s_tready) begin
        seg_fg = $signed(s_tdata[15:0]) > 0;
        ref_fg = $signed(s_tdata[31:16]) > 0;
        vox_total = bump(vox_total);
        if (seg_fg) fg_seg = bump(fg_seg);
        if (ref_fg) fg_ref = bump(fg_ref);
        if (seg_fg && ref_fg) fg_both = bump(fg_both);
        if (s_tlast) begin
          metrics_due.push_back(close_volume());
          vox_total = 0;
          fg_seg = 0;
          fg_ref = 0;
          fg_both = 0;
        end
      end
      pending = metrics_due.size();
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top for the segmentation overlap metrics unit: clock, reset, voxel stimulus,
// result back-pressure and the verdict. Depends on som_pkg, the RTL and som_checker.
module tb;
  import som_pkg::*;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [31:0] s_tdata;          // [15:0] seg_voxel, [31:16] ref_voxel
  logic s_tlast;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_W-1:0] m_tdata;     // six counts, four ratios, undefined_mask, pad

  int errors;
  int pending;

  // Random idling on both sides; cleared for a long calm stretch
  bit idle_on;
  // Bump to make the result side hold off for a long stretch
  int hold_req;
  int hold_seen;

  segmentation_overlap_metrics_unit dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  som_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .errors  (errors),
    .pending (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one voxel pair at the falling edge, maybe after a few idle cycles, and
  // hold it until the rising edge that takes the request.
  task automatic send_pair(input logic [15:0] seg_v, input logic [15:0] ref_v,
                           input logic is_last);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 12) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {ref_v, seg_v};
    s_tlast <= is_last;
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid and hold until every closed volume has its record back
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Mix of full-range values, values around the foreground threshold and extremes
  function automatic logic [15:0] pick_voxel();
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0: begin
        v = 16'($urandom_range(0, 4));
        v = v - 16'd2;
      end
      1: begin
        case ($urandom_range(0, 4))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'h0000;
          3: v = 16'h0001;
          default: v = 16'hFFFF;
        endcase
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // One volume of random voxel pairs; the reference often follows the segmentation
  // so that overlap is common.
  task automatic send_volume(input int len);
    logic [15:0] seg_v, ref_v;
    for (int i = 0; i < len; i++) begin
      seg_v = pick_voxel();
      ref_v = ($urandom_range(0, 9) < 4) ? seg_v : pick_voxel();
      send_pair(seg_v, ref_v, i == len - 1);
    end
  endtask

  // Result side: random back-pressure, plus a long hold-off on request
  initial begin
    m_tready = 1'b0;
    hold_seen = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        m_tready <= 1'b0;
        repeat (600) @(negedge clk);
      end else begin
        m_tready <= !(idle_on && $urandom_range(0, 99) < 12);
        @(negedge clk);
      end
    end
  end

  // Generous limit: even all one-voxel volumes with every stall stay far below it
  initial begin
    #4000000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    int items;
    int vol;
    int len;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    idle_on = 1'b1;
    hold_req = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed: single-voxel volumes that hit each empty denominator, sign extremes,
    // the threshold values 0 and 1, then a mixed volume and alternating bit patterns.
    send_pair(16'h0000, 16'h0000, 1'b1);  // background only: three ratios undefined
    send_pair(16'h0001, 16'h0001, 1'b1);  // overlap only: specificity undefined
    send_pair(16'h7FFF, 16'hFFFF, 1'b1);  // false positive
    send_pair(16'h8000, 16'h0001, 1'b1);  // false negative
    send_pair(16'hFFFF, 16'h7FFF, 1'b1);
    send_pair(16'h0001, 16'h0001, 1'b0);
    send_pair(16'h0001, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'h0001, 1'b0);
    send_pair(16'h0000, 16'h0000, 1'b0);
    send_pair(16'h8000, 16'h8000, 1'b0);
    send_pair(16'h7FFF, 16'h7FFF, 1'b1);
    send_pair(16'h5555, 16'hAAAA, 1'b0);
    send_pair(16'hAAAA, 16'h5555, 1'b0);
    send_pair(16'h0100, 16'h8001, 1'b1);
    wait_drained();

    // Random volumes, mostly short, now and then a long one
    items = 0;
    vol = 0;
    while (items < 700) begin
      if (vol == 10) idle_on = 1'b0;
      if (vol == 20) idle_on = 1'b1;
      if (vol == 30) begin
        // Hold off the result side while short volumes pile up and stall the input
        hold_req++;
        for (int k = 0; k < 12; k++) begin
          send_volume(1);
          items++;
        end
      end
      if (vol == 45) wait_drained();
      len = ($urandom_range(0, 15) == 0) ? int'($urandom_range(40, 120))
                                          : int'($urandom_range(1, 20));
      send_volume(len);
      items += len;
      vol++;
    end

    wait_drained();
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
